>>> rtl/spo2_ratio_of_ratios_estimator_top_defines.svh
// ---------------------------------------------------------------------------
// SpO2 estimator assertion macros
// Shared property forms for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef SPO2_RATIO_OF_RATIOS_ESTIMATOR_TOP_DEFINES_SVH
`define SPO2_RATIO_OF_RATIOS_ESTIMATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPO2R_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spo2r same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SPO2R_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spo2r next-cycle check failed");

`endif

>>> rtl/spo2r_pkg.sv
// ---------------------------------------------------------------------------
// spo2r_pkg
// Widths, codes and sequencer states of the SpO2 ratio-of-ratios estimator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package spo2r_pkg;

  localparam int WIN_LEN   = 128;
  localparam int WIN_AW    = $clog2(WIN_LEN);
  localparam int FILL_W    = $clog2(WIN_LEN + 1);
  localparam int SUM_CNT_W = $clog2(2 * WIN_LEN + 2);

  localparam int SMP_W  = 18;
  localparam int S1_W   = SMP_W + WIN_AW;
  localparam int S2_W   = 2 * SMP_W + WIN_AW;
  localparam int D_W    = S2_W + WIN_AW;
  localparam int RAD_W  = D_W + (D_W % 2);
  localparam int RMS_W  = RAD_W / 2;
  localparam int REM_W  = RMS_W + 3;
  localparam int ROOT_CNT_W = $clog2(RMS_W + 1);
  localparam int NUM_W  = RMS_W + S1_W;
  localparam int P_W    = NUM_W + 4;

  localparam int Q_FRAC    = 16;
  localparam int Q_W       = 21;
  localparam int DIV_STEPS = 20;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int R2_W      = 25;

  localparam int COEF_W = 32;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Y_W    = 60;
  localparam int PCT_W  = 7;

  localparam logic [Q_W-1:0] R_MAX = Q_W'(16) << Q_FRAC;
  localparam logic signed [Y_W-1:0] Y_FULL = Y_W'(100) << 32;
  localparam logic signed [Y_W-1:0] Y_HALF = Y_W'(1) << 31;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_FILL   = 2'd1;
  localparam logic [1:0] STS_FINGER = 2'd2;
  localparam logic [1:0] STS_FLAT   = 2'd3;

  localparam logic [1:0] REG_DC_MIN = 2'd0;
  localparam logic [1:0] REG_COEF_A = 2'd1;
  localparam logic [1:0] REG_COEF_B = 2'd2;
  localparam logic [1:0] REG_COEF_C = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_SUM, S_DCCHK, S_SQI, S_SQR, S_DR, S_ROOTI, S_ROOTR,
    S_NUM, S_DEN, S_DENT, S_RCHK, S_DIV, S_QQ, S_AR2, S_BR, S_YC, S_FIN, S_EMIT
  } state_t;

endpackage

>>> rtl/spo2r_mul.sv
// ---------------------------------------------------------------------------
// spo2r_mul
// Shared signed multiplier with a registered product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module spo2r_mul (
  input  logic                                 clk,
  input  logic signed [spo2r_pkg::MUL_W-1:0]   op_a,
  input  logic signed [spo2r_pkg::MUL_W-1:0]   op_b,
  output logic signed [spo2r_pkg::PROD_W-1:0]  prod
);
  import spo2r_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

>>> rtl/spo2r_root.sv
// ---------------------------------------------------------------------------
// spo2r_root
// Iterative integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module spo2r_root (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [spo2r_pkg::RAD_W-1:0]     radicand,
  output logic                            done,
  output logic [spo2r_pkg::RMS_W-1:0]     root
);
  import spo2r_pkg::*;

  logic [RAD_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [RMS_W-1:0]      root_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [REM_W-1:0]      rem_sh;
  logic [REM_W-1:0]      trial;
  logic                  ge;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_r, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ROOT_CNT_W'(RMS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ROOT_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RMS_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/spo2r_div.sv
// ---------------------------------------------------------------------------
// spo2r_div
// Restoring divider giving the ratio in Q16, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module spo2r_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [spo2r_pkg::NUM_W-1:0]     num,
  input  logic [spo2r_pkg::NUM_W-1:0]     den,
  output logic                            done,
  output logic [spo2r_pkg::Q_W-1:0]       quo
);
  import spo2r_pkg::*;

  logic [P_W-1:0]       p_r;
  logic [P_W-1:0]       dd_r;
  logic [DIV_STEPS-1:0] q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [P_W:0]         p_sh;
  logic [P_W:0]         p_sub;
  logic                 ge;

  assign p_sh  = {p_r, 1'b0};
  assign ge    = (p_sh >= {1'b0, dd_r});
  assign p_sub = p_sh - {1'b0, dd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r  <= P_W'(num);
      dd_r <= {den, 4'b0000};
      q_r  <= '0;
    end else if (busy_r) begin
      p_r <= ge ? p_sub[P_W-1:0] : p_sh[P_W-1:0];
      q_r <= {q_r[DIV_STEPS-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = Q_W'(q_r);

endmodule

>>> rtl/spo2_ratio_of_ratios_estimator_top.sv
// ---------------------------------------------------------------------------
// spo2_ratio_of_ratios_estimator_top
// SpO2 estimate from IR and red sample windows by the ratio of ratios.
// ---------------------------------------------------------------------------
// Each accepted transfer stores one IR/red sample pair and yields exactly one
// result transfer. While the window is still filling that result carries the
// fill status. Once the window is full, each window entry passes through the
// single shared multiplier, followed by two square roots and a divide unless
// the pair is rejected (finger off, flat IR) or the ratio saturates. in_tready
// is low until the sequencer is back in idle.
// A finished result waits in the output register while the next sample is
// taken. The window memories need no clearing after reset.
`timescale 1ns / 1ps
module spo2_ratio_of_ratios_estimator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // ir_sample[17:0], red_sample[35:18], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // spo2_percent[6:0], zero pad
  output logic [2:0]  out_tuser,  // estimate_valid[0], status[2:1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import spo2r_pkg::*;

  state_t state_r, state_nxt;

  logic [SMP_W-1:0] ir_mem  [WIN_LEN];
  logic [SMP_W-1:0] red_mem [WIN_LEN];
  logic [SMP_W-1:0] rd_ir_r, rd_red_r;
  logic [WIN_AW-1:0] rd_addr;

  logic [WIN_AW-1:0]    wpos_r;
  logic [FILL_W-1:0]    fill_r;
  logic [SUM_CNT_W-1:0] cnt_r;

  logic [SMP_W-1:0]         dc_r;
  logic signed [COEF_W-1:0] a_r, b_r, c_r;

  logic [S1_W-1:0]  s1i_r, s1r_r;
  logic [S2_W-1:0]  s2i_r, s2r_r;
  logic [RAD_W-1:0] di_r, dr_r;
  logic [RMS_W-1:0] rms_i_r, rms_r_r;
  logic [NUM_W-1:0] num_r, den_r;
  logic [Q_W-1:0]   q_r;
  logic signed [Y_W-1:0] y_r;

  logic [PCT_W-1:0] res_pct_r;
  logic             res_ok_r;
  logic [1:0]       res_sts_r;

  logic             out_valid_r;
  logic [PCT_W-1:0] out_pct_r;
  logic             out_ok_r;
  logic [1:0]       out_sts_r;

  logic in_xfer, out_load, fill_done;
  logic [SMP_W-1:0] in_ir, in_red;
  logic [S1_W-1:0]  dc_scaled;
  logic             finger_off, rat_sat;
  logic [D_W-1:0]   ns2i, ns2r;
  logic signed [Y_W-1:0] c_term, y_rnd;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic             sq_start, sq_done, div_start, div_done;
  logic [RAD_W-1:0] sq_rad;
  logic [RMS_W-1:0] sq_root;
  logic [Q_W-1:0]   div_quo;

  spo2r_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  spo2r_root u_root (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sq_rad),
    .done(sq_done), .root(sq_root)
  );

  spo2r_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_r), .den(den_r),
    .done(div_done), .quo(div_quo)
  );

  assign in_ir     = in_tdata[SMP_W-1:0];
  assign in_red    = in_tdata[2*SMP_W-1:SMP_W];
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign fill_done = (fill_r >= FILL_W'(WIN_LEN - 1));
  assign rd_addr   = cnt_r[WIN_AW:1];

  assign dc_scaled  = S1_W'(dc_r) * S1_W'(WIN_LEN);
  assign finger_off = (s1i_r < dc_scaled) || (s1r_r < dc_scaled);
  assign ns2i       = D_W'(s2i_r) * D_W'(WIN_LEN);
  assign ns2r       = D_W'(s2r_r) * D_W'(WIN_LEN);
  assign rat_sat    = (den_r == '0) || ({4'b0000, num_r} >= {den_r, 4'b0000});
  assign c_term     = {{(Y_W-COEF_W-16){c_r[COEF_W-1]}}, c_r, 16'h0000};
  assign y_rnd      = y_r + Y_HALF;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer) state_nxt = fill_done ? S_SUM : S_EMIT;
      S_SUM:   if (cnt_r == SUM_CNT_W'(2 * WIN_LEN + 1)) state_nxt = S_DCCHK;
      S_DCCHK: state_nxt = finger_off ? S_EMIT : S_SQI;
      S_SQI:   state_nxt = S_SQR;
      S_SQR:   state_nxt = S_DR;
      S_DR:    state_nxt = (di_r == '0) ? S_EMIT : S_ROOTI;
      S_ROOTI: if (sq_done) state_nxt = S_ROOTR;
      S_ROOTR: if (sq_done) state_nxt = S_NUM;
      S_NUM:   state_nxt = S_DEN;
      S_DEN:   state_nxt = S_DENT;
      S_DENT:  state_nxt = S_RCHK;
      S_RCHK:  state_nxt = rat_sat ? S_QQ : S_DIV;
      S_DIV:   if (div_done) state_nxt = S_QQ;
      S_QQ:    state_nxt = S_AR2;
      S_AR2:   state_nxt = S_BR;
      S_BR:    state_nxt = S_YC;
      S_YC:    state_nxt = S_FIN;
      S_FIN:   state_nxt = S_EMIT;
      S_EMIT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    sq_rad    = di_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_SUM: begin
        mul_a = $signed(MUL_W'(cnt_r[0] ? rd_ir_r : rd_red_r));
        mul_b = mul_a;
      end
      S_SQI: begin
        mul_a = $signed(MUL_W'(s1i_r));
        mul_b = mul_a;
      end
      S_SQR: begin
        mul_a = $signed(MUL_W'(s1r_r));
        mul_b = mul_a;
      end
      S_DR: sq_start = (di_r != '0);
      S_ROOTI: begin
        sq_start = sq_done;
        sq_rad   = dr_r;
      end
      S_NUM: begin
        mul_a = $signed(MUL_W'(rms_r_r));
        mul_b = $signed(MUL_W'(s1i_r));
      end
      S_DEN: begin
        mul_a = $signed(MUL_W'(rms_i_r));
        mul_b = $signed(MUL_W'(s1r_r));
      end
      S_RCHK: div_start = !rat_sat;
      S_QQ: begin
        mul_a = $signed(MUL_W'(q_r));
        mul_b = mul_a;
      end
      S_AR2: begin
        mul_a = MUL_W'(a_r);
        mul_b = $signed(MUL_W'(prod[Q_FRAC +: R2_W]));
      end
      S_BR: begin
        mul_a = MUL_W'(b_r);
        mul_b = $signed(MUL_W'(q_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ir_mem[wpos_r]  <= in_ir;
      red_mem[wpos_r] <= in_red;
    end
    rd_ir_r  <= ir_mem[rd_addr];
    rd_red_r <= red_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpos_r      <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      dc_r        <= SMP_W'(50000);
      a_r         <= -32'sd2953052;
      b_r         <= 32'sd1989280;
      c_r         <= 32'sd6215762;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_DC_MIN: dc_r <= cfg_wdata[SMP_W-1:0];
          REG_COEF_A: a_r  <= $signed(cfg_wdata);
          REG_COEF_B: b_r  <= $signed(cfg_wdata);
          REG_COEF_C: c_r  <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (in_xfer) begin
        wpos_r <= (wpos_r == WIN_AW'(WIN_LEN - 1)) ? '0 : wpos_r + 1'b1;
        if (!fill_done) fill_r <= fill_r + 1'b1;
        else fill_r <= FILL_W'(WIN_LEN);
        cnt_r <= '0;
      end else if (state_r == S_SUM) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        s1i_r     <= '0;
        s1r_r     <= '0;
        s2i_r     <= '0;
        s2r_r     <= '0;
        res_pct_r <= '0;
        res_ok_r  <= 1'b0;
        res_sts_r <= STS_FILL;
      end
      S_SUM: begin
        if (!cnt_r[0] && cnt_r != '0) begin
          s1i_r <= s1i_r + S1_W'(rd_ir_r);
          s1r_r <= s1r_r + S1_W'(rd_red_r);
          s2i_r <= s2i_r + prod[S2_W-1:0];
        end
        if (cnt_r[0] && cnt_r != SUM_CNT_W'(1)) begin
          s2r_r <= s2r_r + prod[S2_W-1:0];
        end
      end
      S_DCCHK: res_sts_r <= STS_FINGER;
      S_SQR:   di_r <= RAD_W'(ns2i - prod[D_W-1:0]);
      S_DR: begin
        dr_r      <= RAD_W'(ns2r - prod[D_W-1:0]);
        res_sts_r <= STS_FLAT;
      end
      S_ROOTI: if (sq_done) rms_i_r <= sq_root;
      S_ROOTR: if (sq_done) rms_r_r <= sq_root;
      S_DEN:   num_r <= prod[NUM_W-1:0];
      S_DENT:  den_r <= prod[NUM_W-1:0];
      S_RCHK:  q_r <= R_MAX;
      S_DIV:   if (div_done) q_r <= div_quo;
      S_BR:    y_r <= prod[Y_W-1:0];
      S_YC:    y_r <= y_r + prod[Y_W-1:0] + c_term;
      S_FIN: begin
        res_ok_r  <= 1'b1;
        res_sts_r <= STS_OK;
        if (y_r > Y_FULL) res_pct_r <= PCT_W'(100);
        else if (y_r < 0) res_pct_r <= '0;
        else res_pct_r <= y_rnd[32 +: PCT_W];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pct_r <= res_pct_r;
      out_ok_r  <= res_ok_r;
      out_sts_r <= res_sts_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pct_r};
  assign out_tuser  = {out_sts_r, out_ok_r};

endmodule

>>> rtl/spo2r_checker.sv
// ---------------------------------------------------------------------------
// spo2r_checker
// Port-level checks of the SpO2 estimator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spo2_ratio_of_ratios_estimator_top_defines.svh"
module spo2r_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser
);

  `SPO2R_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `SPO2R_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)
  `SPO2R_ASSERT_IMPL(a_pct_range, out_tvalid, out_tdata[6:0] <= 7'd100)
  `SPO2R_ASSERT_IMPL(a_valid_is_ok, out_tvalid, out_tuser[0] == (out_tuser[2:1] == 2'd0))
  `SPO2R_ASSERT_IMPL(a_invalid_zero, out_tvalid && !out_tuser[0], out_tdata[6:0] == 7'd0)

endmodule

bind spo2_ratio_of_ratios_estimator_top spo2r_checker u_spo2r_checker (.*);

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Stream testbench for the SpO2 ratio-of-ratios estimator: random IR/red
// sample pairs go in through the input stream, and a model of the window sums,
// square roots, ratio and calibration quadratic predicts each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import spo2r_pkg::*;

  localparam int NWIN = 128;
  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DC_MIN;
  logic [31:0] cfg_wdata = '0;

  typedef struct packed {
    logic [6:0] pct;
    logic       valid;
    logic [1:0] status;
  } spo2_t;

  spo2_ratio_of_ratios_estimator_top dut (.*);

  always #2 clk = ~clk;

  logic [39:0] sample_q[$];
  spo2_t       spo2_q[$];
  logic [17:0] ir_win[NWIN];
  logic [17:0] red_win[NWIN];
  int          wr_pos;
  int          fill_cnt;
  logic [17:0] dc_min;
  longint      coef_a, coef_b, coef_c;
  int          errors = 0;
  int          n_sent = 0;
  int          n_recv = 0;
  int          n_ok = 0;
  int          n_other = 0;
  longint      cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic spo2_t predict_spo2(logic [39:0] d);
    spo2_t o;
    longint unsigned s1i, s1r, s2i, s2r, di, dr, ri, rr, num, den, q, rem, a, b;
    longint r, r2, y;
    o = '0;
    ir_win[wr_pos] = d[17:0];
    red_win[wr_pos] = d[35:18];
    wr_pos = (wr_pos + 1) % NWIN;
    if (fill_cnt < NWIN) fill_cnt++;
    if (fill_cnt < NWIN) begin
      o.status = STS_FILL;
      return o;
    end
    s1i = 0; s1r = 0; s2i = 0; s2r = 0;
    for (int i = 0; i < NWIN; i++) begin
      a = ir_win[i];
      b = red_win[i];
      s1i += a; s1r += b; s2i += a * a; s2r += b * b;
    end
    if (s1i < 64'(dc_min) * NWIN || s1r < 64'(dc_min) * NWIN) begin
      o.status = STS_FINGER;
      return o;
    end
    di = NWIN * s2i - s1i * s1i;
    dr = NWIN * s2r - s1r * s1r;
    if (di == 0) begin
      o.status = STS_FLAT;
      return o;
    end
    ri = int_sqrt(di);
    rr = int_sqrt(dr);
    num = rr * s1i;
    den = ri * s1r;
    if (den == 0 || num >= 16 * den) begin
      q = 64'd16 << 16;
    end else begin
      rem = num % den;
      q = num / den;
      for (int i = 0; i < 16; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
    end
    r = longint'(q);
    r2 = longint'((q * q) >> 16);
    y = coef_a * r2 + coef_b * r + coef_c * 65536;
    o.valid = 1'b1;
    o.status = STS_OK;
    if (y > 100 * 64'sh100000000) o.pct = 7'd100;
    else if (y < 0) o.pct = 7'd0;
    else o.pct = 7'((longint'(y) + 64'sh80000000) >>> 32);
    return o;
  endfunction

  always @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      spo2_q.push_back(predict_spo2(in_tdata));
      n_sent++;
    end
    if (!(in_tvalid && !in_tready)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_tdata <= sample_q.pop_front();
        in_tvalid <= 1'b1;
        in_gap <= rand_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    spo2_t got, exp_v;
    if (out_tvalid && out_tready) begin
      got.pct = out_tdata[6:0];
      got.valid = out_tuser[0];
      got.status = out_tuser[2:1];
      n_recv++;
      if (spo2_q.size() == 0) begin
        $display("%0t: unexpected result pct=%0d valid=%0d status=%0d", $time,
                 got.pct, got.valid, got.status);
        errors++;
      end else begin
        exp_v = spo2_q.pop_front();
        if (got.status == STS_OK) n_ok++; else n_other++;
        if (got.pct !== exp_v.pct)
          begin $display("%0t: pct expected %0d actual %0d", $time, exp_v.pct, got.pct); errors++; end
        if (got.valid !== exp_v.valid)
          begin $display("%0t: valid expected %0d actual %0d", $time, exp_v.valid, got.valid); errors++; end
        if (got.status !== exp_v.status)
          begin $display("%0t: status expected %0d actual %0d", $time, exp_v.status, got.status); errors++; end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= rand_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL spo2_ratio_of_ratios_estimator_top");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DC_MIN: dc_min = val[17:0];
      REG_COEF_A: coef_a = longint'(signed'(val));
      REG_COEF_B: coef_b = longint'(signed'(val));
      REG_COEF_C: coef_c = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (sample_q.size() == 0);
    @(posedge clk);
    while (in_tvalid || spo2_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // base: DC level; ac: swing amplitude of each channel
  task automatic queue_pulse(int cnt, int base_ir, int ac_ir, int base_red, int ac_red);
    int ir, rd;
    for (int i = 0; i < cnt; i++) begin
      ir = base_ir + $urandom_range(0, ac_ir);
      rd = base_red + $urandom_range(0, ac_red);
      if (ir > 262143) ir = 262143;
      if (rd > 262143) rd = 262143;
      sample_q.push_back({4'b0, 18'(rd), 18'(ir)});
    end
  endtask

  task automatic queue_noise(int cnt);
    for (int i = 0; i < cnt; i++)
      sample_q.push_back({4'b0, 18'($urandom), 18'($urandom)});
  endtask

  initial begin
    wr_pos = 0;
    fill_cnt = 0;
    dc_min = 18'd50000;
    coef_a = -2953052;
    coef_b = 1989280;
    coef_c = 6215762;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // fill with extremes, then flat IR, then low samples in a full window
    sample_q.push_back({4'b0, 18'h3FFFF, 18'h3FFFF});
    sample_q.push_back({4'b0, 18'h0, 18'h0});
    queue_pulse(128, 262143, 0, 100000, 20000);
    queue_pulse(5, 0, 1000, 0, 1000);
    drain();
    write_reg(REG_DC_MIN, 32'd0);
    write_reg(REG_COEF_A, 32'h8000_0000);
    write_reg(REG_COEF_B, 32'h7FFF_FFFF);
    write_reg(REG_COEF_C, 32'h0000_0000);
    // red zero gives saturated ratio; also ir/red extremes with threshold zero
    queue_pulse(130, 0, 262143, 0, 0);
    queue_pulse(10, 0, 262143, 0, 262143);
    drain();
    write_reg(REG_DC_MIN, 32'h3FFFF);
    write_reg(REG_COEF_A, 32'h7FFF_FFFF);
    write_reg(REG_COEF_B, 32'h8000_0000);
    write_reg(REG_COEF_C, 32'hFFFF_FFFF);
    queue_pulse(20, 200000, 62143, 200000, 62143);
    drain();
    write_reg(REG_DC_MIN, 32'd50000);
    write_reg(REG_COEF_A, 32'hFFD2_F0A4);
    write_reg(REG_COEF_B, 32'd1989280);
    write_reg(REG_COEF_C, 32'd6215762);
    for (int blk = 0; blk < 18; blk++) begin
      case ($urandom_range(0, 5))
        0: queue_noise(20);
        1: queue_pulse(40, 20000, 70000, 20000, 70000);
        2: queue_pulse(40, $urandom_range(0, 60000), 2000, $urandom_range(0, 60000), 2000);
        default: queue_pulse(40, $urandom_range(40000, 200000), $urandom_range(0, 8000),
                             $urandom_range(40000, 200000), $urandom_range(0, 8000));
      endcase
    end
    drain();
    write_reg(REG_COEF_A, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
    write_reg(REG_COEF_B, $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
    write_reg(REG_COEF_C, $urandom_range(0, 32'h0100_0000));
    queue_pulse(200, 100000, 30000, 90000, 20000);
    queue_pulse(15, 100000, 3000, 90000, 9000);
    drain();
    $display("sent %0d sample pairs, checked %0d results (%0d estimates, %0d status-only)",
             n_sent, n_recv, n_ok, n_other);
    if (errors == 0 && spo2_q.size() == 0) begin
      $display("PASS spo2_ratio_of_ratios_estimator_top");
    end else begin
      $display("FAIL spo2_ratio_of_ratios_estimator_top");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/spo2r_pkg.sv
rtl/spo2r_mul.sv
rtl/spo2r_root.sv
rtl/spo2r_div.sv
rtl/spo2_ratio_of_ratios_estimator_top.sv
rtl/spo2r_checker.sv
dv/tb_top.sv
